// File: rtl/pngu_pkg.sv
`default_nettype none

package pngu_pkg;

    localparam int MAX_ROW_BYTES = 8192;
    localparam int IDX_W         = $clog2(MAX_ROW_BYTES);
    localparam int COL_W         = IDX_W + 1;
    localparam int BPP_W         = 4;
    localparam int SHIFT_W       = 3;
    localparam int RB_W          = 14;
    localparam int ROW_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_BPP       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // One data or error item on its way from the control stage to reconstruction
    typedef struct packed {
        logic               valid;
        logic               bad;
        logic [2:0]         filter;
        logic [IDX_W-1:0]   idx;
        logic [SHIFT_W-1:0] shift;
        logic               have_left;
        logic               have_up;
        logic               last;
        logic               image_end;
        logic [7:0]         data;
    } pngu_item_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } pngu_rd_t;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        // pa = |p - a| = |b - c|, pb = |a - c|, pc = |a + b - 2c|
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pngu_ctrl.sv
`default_nettype none

module pngu_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pngu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             image_start,
    input  wire logic                             item_go,
    output pngu_pkg::pngu_item_t                  item,
    output pngu_pkg::pngu_rd_t                    rd
);
    import pngu_pkg::*;

    localparam int RBX_W = (COL_W > RB_W) ? COL_W : RB_W;

    logic [BPP_W-1:0] bpp_reg;
    logic [RB_W-1:0]  row_bytes_reg;
    logic [ROW_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg,    col_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic [2:0]       filter_reg, filter_next;
    logic             fault_reg,  fault_next;
    pngu_item_t       item_reg,   item_next;

    logic [BPP_W-1:0] bpp_eff;
    logic [RBX_W-1:0] rb_ext;
    logic [COL_W-1:0] rb_eff;
    logic [ROW_W-1:0] h_eff;
    logic [COL_W-1:0] eff_col;
    logic [ROW_W-1:0] eff_row;
    logic             eff_fault;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             accept;

    always_comb
    begin
        if (bpp_reg == '0)
            bpp_eff = BPP_W'(1);
        else if (bpp_reg > BPP_W'(MAX_BPP))
            bpp_eff = BPP_W'(MAX_BPP);
        else
            bpp_eff = bpp_reg;

        rb_ext = RBX_W'(row_bytes_reg);
        if (rb_ext == '0)
            rb_ext = RBX_W'(1);
        else if (rb_ext > RBX_W'(MAX_ROW_BYTES))
            rb_ext = RBX_W'(MAX_ROW_BYTES);
        rb_eff = COL_W'(rb_ext);

        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    assign s_tready = !item_reg.valid || item_go;
    assign accept   = s_tvalid && s_tready;

    assign eff_col   = image_start ? '0 : col_reg;
    assign eff_row   = image_start ? '0 : row_reg;
    assign eff_fault = image_start ? 1'b0 : fault_reg;
    assign idx       = IDX_W'(eff_col - COL_W'(1));
    // column count is index + 1, so the row ends once it reaches the row length
    assign last      = eff_col >= rb_eff;

    always_comb
    begin
        col_next    = eff_col;
        row_next    = eff_row;
        fault_next  = eff_fault;
        filter_next = filter_reg;
        item_next   = '0;
        item_next.data      = data_byte;
        item_next.idx       = idx;
        item_next.filter    = filter_reg;
        item_next.shift     = SHIFT_W'(bpp_eff - BPP_W'(1));
        item_next.have_left = {1'b0, idx} >= COL_W'(bpp_eff);
        item_next.have_up   = eff_row != '0;

        if (eff_fault || eff_row >= h_eff)
        begin
            // drop until the next image
        end
        else if (eff_col == '0)
        begin
            if (data_byte > 8'(FILT_PAETH))
            begin
                fault_next    = 1'b1;
                item_next.valid = 1'b1;
                item_next.bad   = 1'b1;
            end
            else
            begin
                filter_next = data_byte[2:0];
                col_next    = COL_W'(1);
            end
        end
        else
        begin
            item_next.valid     = 1'b1;
            item_next.last      = last;
            item_next.image_end = last && ({1'b0, eff_row} + 17'd1 >= {1'b0, h_eff});
            if (last)
            begin
                col_next = '0;
                row_next = (eff_row == '1) ? eff_row : eff_row + ROW_W'(1);
            end
            else
            begin
                col_next = eff_col + COL_W'(1);
            end
        end
    end

    assign rd.en   = accept && item_next.valid && !item_next.bad;
    assign rd.addr = idx;
    assign item    = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_W'(1);
            row_bytes_reg <= RB_W'(1);
            height_reg    <= ROW_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            filter_reg    <= FILT_NONE;
            fault_reg     <= 1'b0;
            item_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BYTES_PER_PIXEL: bpp_reg       <= cfg_data[BPP_W-1:0];
                    CFG_ROW_BYTES:       row_bytes_reg <= cfg_data[RB_W-1:0];
                    CFG_IMAGE_HEIGHT:    height_reg    <= cfg_data[ROW_W-1:0];
                    default:             ;
                endcase
            end
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                filter_reg <= filter_next;
                fault_reg  <= fault_next;
                item_reg   <= item_next;
            end
            else if (item_go)
            begin
                item_reg.valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/pngu_recon.sv
`default_nettype none

module pngu_recon (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pngu_pkg::pngu_item_t  item,
    input  wire pngu_pkg::pngu_rd_t    rd,
    output logic                       item_go,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 pixel_byte,
    output logic                       row_end,
    output logic                       image_end,
    output logic                       bad_filter
);
    import pngu_pkg::*;

    logic [7:0]  prior_mem [MAX_ROW_BYTES];
    logic [7:0]  up_reg;
    logic [63:0] left_reg,  left_next;
    logic [63:0] uleft_reg, uleft_next;

    logic        out_valid_reg;
    logic [7:0]  pix_reg;
    logic        row_end_reg;
    logic        image_end_reg;
    logic        bad_reg;

    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [8:0]  avg_sum;
    logic [7:0]  pred;
    logic [7:0]  pix;
    logic        wr_en;

    assign item_go = item.valid && (!out_valid_reg || m_tready);
    assign wr_en   = item_go && !item.bad;

    always_comb
    begin
        a = item.have_left ? left_reg[{item.shift, 3'b000} +: 8] : 8'd0;
        b = item.have_up ? up_reg : 8'd0;
        c = (item.have_up && item.have_left) ? uleft_reg[{item.shift, 3'b000} +: 8] : 8'd0;
        avg_sum = {1'b0, a} + {1'b0, b};
        case (item.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'd0;
        endcase
        pix        = item.data + pred;
        left_next  = {left_reg[55:0], pix};
        uleft_next = {uleft_reg[55:0], b};
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
            up_reg <= prior_mem[rd.addr];
        if (wr_en)
            prior_mem[item.idx] <= pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            uleft_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                left_reg  <= left_next;
                uleft_reg <= uleft_next;
            end
            if (item_go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (item_go)
        begin
            pix_reg       <= item.bad ? 8'd0 : pix;
            row_end_reg   <= item.last;
            image_end_reg <= item.image_end;
            bad_reg       <= item.bad;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign pixel_byte = pix_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;
    assign bad_filter = bad_reg;

endmodule

`default_nettype wire

// File: rtl/png_scanline_unfilter_core.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   tdata = data_byte, tuser = image_start
// m_*      out        m_tvalid/m_tready   tdata = pixel_byte, tlast = row_end,
//                                         tuser = image_end, bad_filter
// cfg_*    in         cfg_we              cfg_index, cfg_data (no read-back)
//
// One item per cycle while results are taken: the control stage registers each
// accepted item while the prior-row memory is read, and the reconstruction stage
// then rebuilds the byte into the result register. Reset clears all control state;
// the prior-row memory is not cleared. A result waiting on m_tready holds only the
// item behind it, so the input keeps flowing as long as the result is taken.
module png_scanline_unfilter_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pngu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tuser,  // [0] image_start
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,  // [7:0] pixel_byte
    output logic                                  m_tlast,  // row_end
    output logic [1:0]                            m_tuser   // [0] image_end, [1] bad_filter
);
    import pngu_pkg::*;

    pngu_item_t item;
    pngu_rd_t   rd;
    logic       item_go;

    pngu_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .data_byte   (s_tdata),
        .image_start (s_tuser),
        .item_go     (item_go),
        .item        (item),
        .rd          (rd)
    );

    pngu_recon u_recon (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .rd         (rd),
        .item_go    (item_go),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .pixel_byte (m_tdata),
        .row_end    (m_tlast),
        .image_end  (m_tuser[0]),
        .bad_filter (m_tuser[1])
    );

endmodule

`default_nettype wire

// File: sim/png_scanline_unfilter_checker.sv
module png_scanline_unfilter_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pngu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tuser,  // [0] image_start
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [7:0]                       m_tdata,  // [7:0] pixel_byte
    input  wire logic                             m_tlast,  // row_end
    input  wire logic [1:0]                       m_tuser,  // [0] image_end, [1] bad_filter
    output int                                    fail_count,
    output int                                    outstanding,
    output int                                    results_checked,
    output int                                    row_ends,
    output int                                    bad_filters
);

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } pixel_result_t;

    pixel_result_t expected_pixels [$];

    // Own copy of the block state and registers
    logic [7:0]  prior_row [0:pngu_pkg::MAX_ROW_BYTES-1];
    logic [63:0] left_hist;
    logic [63:0] upper_hist;
    int          column;
    int          rows_done;
    logic [2:0]  cur_filter;
    bit          faulted;
    logic [3:0]  reg_bpp;
    logic [13:0] reg_row_bytes;
    logic [15:0] reg_height;

    function automatic logic [7:0] paeth_choose(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (a >= p) ? a - p : p - a;
        pb = (b >= p) ? b - p : p - b;
        pc = (c >= p) ? c - p : p - c;
        if (pa <= pb && pa <= pc)
            return 8'(a);
        else if (pb <= pc)
            return 8'(b);
        else
            return 8'(c);
    endfunction

    task automatic rebuild_byte(input logic [7:0] din, input logic start,
                                output bit produced, output pixel_result_t res);
        int         bpp;
        int         rb;
        int         h;
        int         idx;
        int         shift;
        logic [7:0] a;
        logic [7:0] up;
        logic [7:0] ul;
        logic [7:0] pred;
        logic [7:0] pix;
        bit         last;
        produced = 1'b0;
        res      = '0;
        bpp = (reg_bpp == 0) ? 1 : ((reg_bpp > pngu_pkg::MAX_BPP) ? pngu_pkg::MAX_BPP : reg_bpp);
        rb  = (reg_row_bytes == 0) ? 1 : reg_row_bytes;
        if (rb > pngu_pkg::MAX_ROW_BYTES)
            rb = pngu_pkg::MAX_ROW_BYTES;
        h = (reg_height == 0) ? 1 : reg_height;

        if (start) begin
            rows_done  = 0;
            faulted    = 1'b0;
            column     = 0;
            left_hist  = '0;
            upper_hist = '0;
        end
        // drop everything after a fault or past the last row
        if (faulted || rows_done >= h)
            return;

        if (column == 0) begin
            if (din > pngu_pkg::FILT_PAETH) begin
                faulted        = 1'b1;
                res.bad_filter = 1'b1;
                produced       = 1'b1;
                return;
            end
            cur_filter = din[2:0];
            column     = 1;
            left_hist  = '0;
            upper_hist = '0;
            return;
        end

        idx   = column - 1;
        shift = (bpp - 1) * 8;
        a     = (idx >= bpp) ? left_hist[shift +: 8] : 8'h00;
        up    = (rows_done > 0) ? prior_row[idx] : 8'h00;
        ul    = (rows_done > 0 && idx >= bpp) ? upper_hist[shift +: 8] : 8'h00;
        case (cur_filter)
            pngu_pkg::FILT_SUB:   pred = a;
            pngu_pkg::FILT_UP:    pred = up;
            pngu_pkg::FILT_AVG:   pred = 8'(({1'b0, a} + {1'b0, up}) >> 1);
            pngu_pkg::FILT_PAETH: pred = paeth_choose(a, up, ul);
            default:              pred = 8'h00;
        endcase
        pix = din + pred;

        prior_row[idx] = pix;
        left_hist      = {left_hist[55:0], pix};
        upper_hist     = {upper_hist[55:0], up};

        last           = (idx + 1) >= rb;
        res.pixel_byte = pix;
        res.row_end    = last;
        res.image_end  = last && (rows_done + 1 >= h);
        produced       = 1'b1;
        if (last) begin
            column    = 0;
            rows_done = rows_done + 1;
        end
        else begin
            column = idx + 2;
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bit            produced;
        pixel_result_t res;
        pixel_result_t want;
        if (!rst_n) begin
            expected_pixels.delete();
            left_hist       = '0;
            upper_hist      = '0;
            column          = 0;
            rows_done       = 0;
            cur_filter      = pngu_pkg::FILT_NONE;
            faulted         = 1'b0;
            reg_bpp         = 4'd1;
            reg_row_bytes   = 14'd1;
            reg_height      = 16'd1;
            fail_count      = 0;
            results_checked = 0;
            row_ends        = 0;
            bad_filters     = 0;
            outstanding    <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    pngu_pkg::CFG_BYTES_PER_PIXEL: reg_bpp       = cfg_data[3:0];
                    pngu_pkg::CFG_ROW_BYTES:       reg_row_bytes = cfg_data[13:0];
                    pngu_pkg::CFG_IMAGE_HEIGHT:    reg_height    = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                rebuild_byte(s_tdata, s_tuser, produced, res);
                if (produced)
                    expected_pixels.push_back(res);
            end

            if (m_tvalid && m_tready) begin
                results_checked++;
                if (m_tlast)
                    row_ends++;
                if (m_tuser[1])
                    bad_filters++;
                if (expected_pixels.size() == 0) begin
                    $error("pixel_byte: result with no item expected, actual 0x%0h", m_tdata);
                    fail_count++;
                end
                else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_byte", want.pixel_byte, m_tdata);
                    check_field("row_end", want.row_end, m_tlast);
                    check_field("image_end", want.image_end, m_tuser[0]);
                    check_field("bad_filter", want.bad_filter, m_tuser[1]);
                end
            end

            outstanding <= expected_pixels.size();
        end
    end

endmodule

// File: sim/png_scanline_unfilter_core_tb.sv
module png_scanline_unfilter_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 8;
    localparam int NUM_DIRECTED   = 24;
    localparam int WIDE_BYTES     = 16;

    localparam logic [pngu_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {MIX_NONE, MIX_SENDER, MIX_RECEIVER, MIX_BOTH} idle_mix_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [pngu_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [pngu_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata   = '0;   // [7:0] data_byte
    logic                               s_tuser   = 1'b0; // [0] image_start
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [7:0]                         m_tdata;          // [7:0] pixel_byte
    logic                               m_tlast;          // row_end
    logic [1:0]                         m_tuser;          // [0] image_end, [1] bad_filter

    int fail_count;
    int outstanding;
    int results_checked;
    int row_ends;
    int bad_filters;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit hold_request  = 1'b0;
    int quiet_cycles  = 0;
    int items_sent    = 0;
    int settings_done = 0;
    int eff_rb        = 1;
    int eff_h         = 1;

    always #5 clk = ~clk;

    png_scanline_unfilter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    png_scanline_unfilter_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .row_ends        (row_ends),
        .bad_filters     (bad_filters)
    );

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic set_idle_mix(input idle_mix_t mix);
        case (mix)
            MIX_SENDER:   begin tx_idle_pct = 51; rx_stall_pct = 0;  end
            MIX_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
            MIX_BOTH:     begin tx_idle_pct = 10; rx_stall_pct = 10; end
            default:      begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] din, input logic start);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= din;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drain results, then let any item that gives no result clear the pipeline
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [3:0] bpp, input logic [13:0] rb,
                                  input logic [15:0] h);
        wait_idle();
        // upper bits beyond each register width are random and must be ignored
        cfg_we    <= 1'b1;
        cfg_index <= pngu_pkg::CFG_BYTES_PER_PIXEL;
        cfg_data  <= {12'($urandom), bpp};
        @(posedge clk);
        cfg_index <= pngu_pkg::CFG_ROW_BYTES;
        cfg_data  <= {2'($urandom), rb};
        @(posedge clk);
        cfg_index <= pngu_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_rb = (rb == 0) ? 1 : ((rb > pngu_pkg::MAX_ROW_BYTES) ? pngu_pkg::MAX_ROW_BYTES : rb);
        eff_h  = (h == 0) ? 1 : h;
        settings_done++;
    endtask

    // One image: mostly well-formed rows, with bad filter codes, cut rows
    // and trailing bytes past the last row mixed in
    task automatic send_image();
        int         n_rows;
        int         r;
        int         k;
        logic [7:0] filt;
        n_rows = (eff_h > 6) ? $urandom_range(1, 6) : eff_h;
        for (r = 0; r < n_rows; r++) begin
            if ($urandom_range(99) < 6)
                filt = 8'($urandom_range(5, 255));
            else
                filt = 8'($urandom_range(0, 4));
            send_byte(filt, r == 0);
            if (filt > pngu_pkg::FILT_PAETH) begin
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
                return;
            end
            for (k = 0; k < eff_rb; k++) begin
                // cut the row; the next image start truncates it
                if (eff_rb <= 64 && $urandom_range(199) == 0)
                    return;
                send_byte(8'($urandom), 1'b0);
            end
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    logic [8:0]  directed_items [NUM_DIRECTED];
    logic [3:0]  phase_bpp [NUM_PHASES];
    logic [13:0] phase_rb  [NUM_PHASES];
    logic [15:0] phase_h   [NUM_PHASES];

    initial begin
        int i;
        int p;
        int phase_end;

        // {image_start, data_byte}
        directed_items = '{
            9'h100, 9'h000, 9'h0FF, 9'h080,   // None, row 0
            9'h001, 9'h0FF, 9'h001, 9'h07F,   // Sub
            9'h002, 9'h001, 9'h0FF, 9'h080,   // Up
            9'h003, 9'h0FF, 9'h0FF, 9'h001,   // Average
            9'h004, 9'h080, 9'h000, 9'h0FF,   // Paeth, last row
            9'h0AA,                           // past the last row
            9'h1FF, 9'h000,                   // bad filter, then dropped byte
            9'h105                            // smallest bad filter
        };
        phase_bpp = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8};
        phase_rb  = '{14'd1, 14'd16, 14'd5, 14'd9, 14'd0, 14'd24, 14'd3, 14'd2};
        phase_h   = '{16'd1, 16'd3, 16'd2, 16'd4, 16'd2, 16'd0, 16'd3, 16'hFFFF};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle_mix(MIX_NONE);
        write_settings(4'd1, 14'd3, 16'd5);
        for (i = 0; i < NUM_DIRECTED; i++)
            send_byte(directed_items[i][7:0], directed_items[i][8]);

        for (p = 0; p < NUM_PHASES; p++) begin
            write_settings(phase_bpp[p], phase_rb[p], phase_h[p]);
            set_idle_mix(idle_mix_t'(p % 4));
            // long output hold-off while input keeps coming
            if (p == 4)
                hold_request = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_image();
        end

        // widest rows: row_bytes above the maximum acts as the maximum;
        // send only the head of one such row
        write_settings(4'd8, 14'h3FFF, 16'd2);
        set_idle_mix(MIX_NONE);
        send_byte(8'(pngu_pkg::FILT_AVG), 1'b1);
        repeat (WIDE_BYTES) send_byte(8'($urandom), 1'b0);

        set_idle_mix(MIX_BOTH);
        wait_idle();

        $display("Sent %0d bytes under %0d register settings, all idle mixes and one long stall.",
                 items_sent, settings_done);
        $display("Checked %0d results: %0d row ends, %0d bad filter codes.",
                 results_checked, row_ends, bad_filters);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
